// ===== design/csq_pkg.sv =====
`timescale 1ns / 1ps

package csq_pkg;

	// Field widths fixed by the command and result formats.
	localparam int CMD_W = 2;
	localparam int TASK_W = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W = 16;

	// Default number of wait queue entries.
	localparam int QUEUE_DEPTH_DEF = 16;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_WAIT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POST = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_INIT = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_YIELD = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_CLOSED = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_RELEASED = 3'd4;

	// Input word: one semaphore command.
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [TASK_W-1:0] task_id;
	} in_word_t;

	// Output word: one result of a command.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                woken_valid;
		logic [TASK_W-1:0]   woken_task;
		logic                last;
	} out_word_t;

endpackage

// ===== design/counting_semaphore_wait_queue.sv =====
`timescale 1ns / 1ps

// Counting semaphore with a FIFO wait queue of blocked task ids, held in a
// single-port-write, single-port-read RAM with a registered read port.
// Wait, init, and a post that finds no waiter or a closed semaphore load
// their result word straight from the idle state. A post that hands its
// unit to a waiter first reads the waiter id from the RAM, then loads its
// result in the pop state. Close reads each queued waiter id in turn and
// issues a released word for it, then a final word. Commands are
// processed one at a time; a single output register holds the pending
// result word, and a new command is taken while that word is being drained.
module counting_semaphore_wait_queue #(
	parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [csq_pkg::COUNT_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  csq_pkg::in_word_t          in_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output csq_pkg::out_word_t         out_word
);
	import csq_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

	// Control states.
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP = 2'd1;
	localparam logic [1:0] S_CL_RD = 2'd2;
	localparam logic [1:0] S_CL_OUT = 2'd3;

	logic [1:0]         state_q, state_d;
	logic [COUNT_W-1:0] init_count_q;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               open_q, open_d;
	logic [IDX_W-1:0]   head_q, head_d;
	logic [IDX_W-1:0]   tail_q, tail_d;
	logic [FILL_W-1:0]  fill_q, fill_d;
	logic               out_valid_q;
	out_word_t          out_word_q;
	out_word_t          out_next;
	logic               out_load;
	logic               out_free;
	logic               in_fire;
	logic               wr_en;
	logic               rd_en;
	logic [TASK_W-1:0]  rd_data;
	logic [IDX_W-1:0]   head_inc;
	logic [IDX_W-1:0]   tail_inc;

	// Waiter id storage.
	csq_waiter_ram #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.IDX_W(IDX_W)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(tail_q),
		.wr_data(in_word.task_id),
		.rd_en(rd_en),
		.rd_addr(head_q),
		.rd_data(rd_data)
	);

	// Handshake helpers: the output register is free when empty or draining.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_fire = in_valid && !in_stall;
	assign head_inc = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;

	// Command sequencing and read-modify-write of the queue pointers.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		open_d = open_q;
		head_d = head_q;
		tail_d = tail_q;
		fill_d = fill_q;
		wr_en = 1'b0;
		rd_en = 1'b0;
		out_load = 1'b0;
		out_next = '{status: STAT_OK, woken_valid: 1'b0, woken_task: '0, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					unique case (in_word.cmd)
						CMD_WAIT: begin
							out_load = 1'b1;
							if (!open_q) begin
								out_next.status = STAT_CLOSED;
							end else if (count_q != '0) begin
								count_d = count_q - 1'b1;
							end else if (fill_q == FILL_FULL) begin
								out_next.status = STAT_FULL;
							end else begin
								wr_en = 1'b1;
								tail_d = tail_inc;
								fill_d = fill_q + 1'b1;
								out_next.status = STAT_YIELD;
							end
						end
						CMD_POST: begin
							if (!open_q) begin
								out_load = 1'b1;
								out_next.status = STAT_CLOSED;
							end else if (fill_q != '0) begin
								rd_en = 1'b1;
								head_d = head_inc;
								fill_d = fill_q - 1'b1;
								state_d = S_POP;
							end else begin
								out_load = 1'b1;
								out_next.status = STAT_YIELD;
								if (count_q != '1) begin
									count_d = count_q + 1'b1;
								end
							end
						end
						CMD_CLOSE: begin
							state_d = S_CL_RD;
						end
						CMD_INIT: begin
							out_load = 1'b1;
							open_d = 1'b1;
							count_d = init_count_q;
							head_d = '0;
							tail_d = '0;
							fill_d = '0;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_POP: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next = '{status: STAT_YIELD, woken_valid: 1'b1,
						woken_task: rd_data, last: 1'b1};
					state_d = S_IDLE;
				end
			end
			S_CL_RD: begin
				if (fill_q != '0) begin
					rd_en = 1'b1;
					head_d = head_inc;
					fill_d = fill_q - 1'b1;
					state_d = S_CL_OUT;
				end else if (out_free) begin
					out_load = 1'b1;
					open_d = 1'b0;
					head_d = '0;
					tail_d = '0;
					state_d = S_IDLE;
				end
			end
			S_CL_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next = '{status: STAT_RELEASED, woken_valid: 1'b1,
						woken_task: rd_data, last: 1'b0};
					state_d = S_CL_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			init_count_q <= '0;
			count_q <= '0;
			open_q <= 1'b1;
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			open_q <= open_d;
			head_q <= head_d;
			tail_q <= tail_d;
			fill_q <= fill_d;
			if (cfg_wen) begin
				init_count_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_word_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	// The queue never holds more waiters than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FILL_FULL)
		else $error("wait queue fill count exceeds its depth");

	// An empty queue has its pointers together.
	assert property (@(posedge clk) disable iff (!arst_n) (fill_q == '0) |-> (head_q == tail_q))
		else $error("empty wait queue with head and tail apart");

	// A closed semaphore holds no waiters.
	assert property (@(posedge clk) disable iff (!arst_n) !open_q |-> (fill_q == '0))
		else $error("closed semaphore still has queued waiters");

	// Entering the pop state follows exactly one dequeue.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && (state_d == S_POP) |=> (fill_q == $past(fill_q) - 1'b1))
		else $error("post to a waiter did not dequeue one entry");

endmodule

// ===== design/csq_waiter_ram.sv =====
`timescale 1ns / 1ps

module csq_waiter_ram #(
	parameter int QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF,
	parameter int IDX_W = $clog2(QUEUE_DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_addr,
	input  logic [csq_pkg::TASK_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [IDX_W-1:0]          rd_addr,
	output logic [csq_pkg::TASK_W-1:0] rd_data
);
	import csq_pkg::*;

	logic [TASK_W-1:0] mem_q [QUEUE_DEPTH];
	logic [TASK_W-1:0] rd_data_q;

	// Write port: one queued task id per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port with registered data; it holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import csq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS = 38;

	// One row of the directed script: either a register write or a command,
	// repeated with a rising task id, with an optional hand-written result.
	typedef struct {
		bit          is_cfg;
		logic [15:0] value;
		logic [1:0]  cmd;
		logic [7:0]  tid;
		int          reps;
		bit          pinned;
		out_word_t   want;
	} script_row_t;

	// Hand-written result that travels with a command until it is accepted.
	typedef struct {
		bit        pinned;
		out_word_t want;
	} pin_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_wen = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;

	// Shadow of the semaphore as the testbench expects it to be.
	logic [15:0] sem_units;
	bit          sem_accepting;
	logic [7:0]  sem_waiters[$];
	logic [15:0] sem_init_count;

	out_word_t   step_words[$];
	out_word_t   pending_results[$];
	pin_t        pins[$];
	script_row_t script[$];

	int unsigned cmds_issued = 0;
	int unsigned cmds_taken = 0;
	int unsigned words_checked = 0;
	int unsigned fails = 0;
	int unsigned longest_burst = 0;
	int unsigned kind_seen[4] = '{0, 0, 0, 0};
	int unsigned cycles = 0;
	int unsigned stall_run = 0;
	bit          calm = 1'b0;

	counting_semaphore_wait_queue #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic out_word_t mk(logic [2:0] status, logic valid, logic [7:0] tid,
			logic fin);
		out_word_t o;
		o.status = status;
		o.woken_valid = valid;
		o.woken_task = tid;
		o.last = fin;
		return o;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Applies one command to the shadow semaphore and lists its result words.
	function automatic void semaphore_step(in_word_t w);
		step_words.delete();
		case (w.cmd)
			CMD_WAIT: begin
				if (!sem_accepting) begin
					step_words.push_back(mk(STAT_CLOSED, 1'b0, 8'h00, 1'b1));
				end else if (sem_units != 0) begin
					sem_units = sem_units - 1'b1;
					step_words.push_back(mk(STAT_OK, 1'b0, 8'h00, 1'b1));
				end else if (sem_waiters.size() >= DEPTH) begin
					step_words.push_back(mk(STAT_FULL, 1'b0, 8'h00, 1'b1));
				end else begin
					sem_waiters.push_back(w.task_id);
					step_words.push_back(mk(STAT_YIELD, 1'b0, 8'h00, 1'b1));
				end
			end
			CMD_POST: begin
				if (!sem_accepting) begin
					step_words.push_back(mk(STAT_CLOSED, 1'b0, 8'h00, 1'b1));
				end else if (sem_waiters.size() != 0) begin
					step_words.push_back(mk(STAT_YIELD, 1'b1, sem_waiters.pop_front(), 1'b1));
				end else begin
					if (sem_units != 16'hFFFF)
						sem_units = sem_units + 1'b1;
					step_words.push_back(mk(STAT_YIELD, 1'b0, 8'h00, 1'b1));
				end
			end
			CMD_CLOSE: begin
				while (sem_waiters.size() != 0)
					step_words.push_back(mk(STAT_RELEASED, 1'b1, sem_waiters.pop_front(), 1'b0));
				sem_accepting = 1'b0;
				step_words.push_back(mk(STAT_OK, 1'b0, 8'h00, 1'b1));
			end
			CMD_INIT: begin
				sem_accepting = 1'b1;
				sem_units = sem_init_count;
				sem_waiters.delete();
				step_words.push_back(mk(STAT_OK, 1'b0, 8'h00, 1'b1));
			end
		endcase
	endfunction

	// Presents one command word after a random gap (none while calm) and holds it until taken.
	task automatic send_cmd(input in_word_t w, input bit pinned, input out_word_t want);
		int gap;
		pin_t p;
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p.pinned = pinned;
		p.want = want;
		pins.push_back(p);
		cmds_issued++;
		in_word <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Stops sending and waits until every expected result word has come.
	task automatic settle();
		in_valid <= 1'b0;
		while (cmds_taken != cmds_issued || pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_count(input logic [15:0] value);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sem_init_count = value;
	endtask

	function automatic void add_row(bit is_cfg, logic [15:0] value, logic [1:0] cmd,
			logic [7:0] tid, int reps, bit pinned, out_word_t want);
		script_row_t row;
		row.is_cfg = is_cfg;
		row.value = value;
		row.cmd = cmd;
		row.tid = tid;
		row.reps = reps;
		row.pinned = pinned;
		row.want = want;
		script.push_back(row);
	endfunction

	// Receiver stall pattern: runs of stall and of flow, with calm stretches.
	always @(posedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
			stall_run <= 0;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 40);
			stall_run <= gap_len();
		end
	end

	// Takes accepted commands into the shadow and checks each result word.
	always @(posedge clk) begin
		pin_t p;
		out_word_t exp_w;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				p = pins.pop_front();
				semaphore_step(in_word);
				kind_seen[in_word.cmd]++;
				if (step_words.size() > longest_burst)
					longest_burst = step_words.size();
				if (p.pinned)
					pending_results.push_back(p.want);
				else
					foreach (step_words[i])
						pending_results.push_back(step_words[i]);
				cmds_taken++;
			end
			if (out_valid && !out_stall) begin
				words_checked++;
				if (pending_results.size() == 0) begin
					$error("result word with nothing expected: %h", out_word);
					fails++;
				end else begin
					exp_w = pending_results.pop_front();
					if (out_word.status !== exp_w.status) begin
						$error("status: expected %0d, got %0d", exp_w.status, out_word.status);
						fails++;
					end
					if (out_word.woken_valid !== exp_w.woken_valid) begin
						$error("woken_valid: expected %0d, got %0d", exp_w.woken_valid,
							out_word.woken_valid);
						fails++;
					end
					if (out_word.woken_task !== exp_w.woken_task) begin
						$error("woken_task: expected %0h, got %0h", exp_w.woken_task,
							out_word.woken_task);
						fails++;
					end
					if (out_word.last !== exp_w.last) begin
						$error("last: expected %0d, got %0d", exp_w.last, out_word.last);
						fails++;
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		in_word_t w;
		logic [15:0] phase_count[RANDOM_PHASES];
		int wait_pct;
		int r;

		sem_units = '0;
		sem_accepting = 1'b1;
		sem_init_count = '0;

		// Directed script. The first block runs with a zero load count: the
		// queue fills to the brim, a close drains all of it, and commands on
		// a closed semaphore are refused. The second block loads the largest
		// count so that a post saturates.
		add_row(1'b1, 16'h0000, CMD_WAIT, 8'h00, 1, 1'b0, '0);
		add_row(1'b0, '0, CMD_POST, 8'h00, 1, 1'b1, mk(STAT_YIELD, 1'b0, 8'h00, 1'b1));
		add_row(1'b0, '0, CMD_WAIT, 8'hFF, 1, 1'b1, mk(STAT_OK, 1'b0, 8'h00, 1'b1));
		add_row(1'b0, '0, CMD_WAIT, 8'h00, DEPTH, 1'b0, '0);
		add_row(1'b0, '0, CMD_WAIT, 8'hA5, 1, 1'b1, mk(STAT_FULL, 1'b0, 8'h00, 1'b1));
		add_row(1'b0, '0, CMD_CLOSE, 8'h00, 1, 1'b0, '0);
		add_row(1'b0, '0, CMD_POST, 8'h00, 1, 1'b1, mk(STAT_CLOSED, 1'b0, 8'h00, 1'b1));
		add_row(1'b0, '0, CMD_WAIT, 8'h3C, 1, 1'b1, mk(STAT_CLOSED, 1'b0, 8'h00, 1'b1));
		add_row(1'b0, '0, CMD_CLOSE, 8'hFF, 1, 1'b1, mk(STAT_OK, 1'b0, 8'h00, 1'b1));
		add_row(1'b0, '0, CMD_INIT, 8'h00, 1, 1'b1, mk(STAT_OK, 1'b0, 8'h00, 1'b1));
		add_row(1'b0, '0, CMD_WAIT, 8'h5A, 1, 1'b0, '0);
		add_row(1'b0, '0, CMD_POST, 8'h00, 1, 1'b1, mk(STAT_YIELD, 1'b1, 8'h5A, 1'b1));
		add_row(1'b0, '0, CMD_WAIT, 8'hC3, 1, 1'b0, '0);
		add_row(1'b0, '0, CMD_INIT, 8'h00, 1, 1'b1, mk(STAT_OK, 1'b0, 8'h00, 1'b1));
		add_row(1'b0, '0, CMD_POST, 8'h00, 1, 1'b1, mk(STAT_YIELD, 1'b0, 8'h00, 1'b1));
		add_row(1'b1, 16'hFFFF, CMD_WAIT, 8'h00, 1, 1'b0, '0);
		add_row(1'b0, '0, CMD_INIT, 8'h00, 1, 1'b1, mk(STAT_OK, 1'b0, 8'h00, 1'b1));
		add_row(1'b0, '0, CMD_POST, 8'h00, 1, 1'b1, mk(STAT_YIELD, 1'b0, 8'h00, 1'b1));
		add_row(1'b0, '0, CMD_WAIT, 8'h81, 1, 1'b1, mk(STAT_OK, 1'b0, 8'h00, 1'b1));
		add_row(1'b0, '0, CMD_CLOSE, 8'h00, 1, 1'b1, mk(STAT_OK, 1'b0, 8'h00, 1'b1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				settle();
				write_count(script[i].value);
			end else begin
				for (int k = 0; k < script[i].reps; k++) begin
					w.cmd = script[i].cmd;
					w.task_id = script[i].tid + k[7:0];
					send_cmd(w, script[i].pinned, script[i].want);
				end
			end
		end

		// Random phases, each opened by an init under a fresh load count.
		phase_count[0] = 16'h0000;
		phase_count[1] = 16'hFFFF;
		phase_count[2] = 16'h0001;
		phase_count[3] = 16'h0003;
		phase_count[4] = 16'($urandom_range(0, 65535));
		phase_count[5] = 16'h0000;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			write_count(phase_count[ph]);
			calm = (ph == 2);
			wait_pct = $urandom_range(35, 75);
			w.cmd = CMD_INIT;
			w.task_id = 8'($urandom_range(0, 255));
			send_cmd(w, 1'b0, '0);
			for (int n = 1; n < PHASE_WORDS; n++) begin
				r = $urandom_range(0, 99);
				if (r < wait_pct)
					w.cmd = CMD_WAIT;
				else if (r < 88)
					w.cmd = CMD_POST;
				else if (r < 94)
					w.cmd = CMD_CLOSE;
				else
					w.cmd = CMD_INIT;
				w.task_id = 8'($urandom_range(0, 255));
				send_cmd(w, 1'b0, '0);
			end
		end
		calm = 1'b0;

		settle();
		repeat (10) @(posedge clk);

		$display("Run took %0d commands: %0d wait, %0d post, %0d close, %0d init.",
			cmds_taken, kind_seen[CMD_WAIT], kind_seen[CMD_POST],
			kind_seen[CMD_CLOSE], kind_seen[CMD_INIT]);
		$display("Checked %0d result words; the longest burst from one command was %0d.",
			words_checked, longest_burst);
		if (fails == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/csq_pkg.sv
design/csq_waiter_ram.sv
design/counting_semaphore_wait_queue.sv
dv/tb_top.sv
